// File: rtl/brbo_pkg.sv
package brbo_pkg;

   // Number of bytes held by the ring buffer.
   localparam int DEPTH = 2048;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [1:0]       req_code_type;
   typedef logic [7:0]       byte_type;

   localparam req_code_type REQ_WRITE = 2'd0;
   localparam req_code_type REQ_READ  = 2'd1;
   localparam req_code_type REQ_CLEAR = 2'd2;

   localparam ptr_type PTR_LAST = PTR_W'(DEPTH - 1);

   // Pointer increment that wraps at DEPTH, also when DEPTH is not a power of two.
   function automatic ptr_type ptr_next(input ptr_type p);
      ptr_type r;
      r = (p == PTR_LAST) ? '0 : p + ptr_type'(1);
      return r;
   endfunction

endpackage

// File: rtl/brbo_req_if.sv
interface brbo_req_if import brbo_pkg::*;;
   logic         valid;
   logic         ready;
   req_code_type req_type;
   byte_type     write_byte;
   logic         last_in;

   modport source (output valid, output req_type, output write_byte, output last_in,
                   input ready);
   modport sink   (input valid, input req_type, input write_byte, input last_in,
                   output ready);
endinterface

// File: rtl/brbo_rsp_if.sv
interface brbo_rsp_if import brbo_pkg::*;;
   logic     valid;
   logic     ready;
   byte_type read_byte;
   logic     accepted;
   logic     is_empty;
   logic     is_full;
   logic     overflowed;
   logic     last_out;

   modport source (output valid, output read_byte, output accepted, output is_empty,
                   output is_full, output overflowed, output last_out, input ready);
   modport sink   (input valid, input read_byte, input accepted, input is_empty,
                   input is_full, input overflowed, input last_out, output ready);
endinterface

// File: rtl/brbo_ram.sv
module brbo_ram #(
   parameter int DEPTH_P  = 2048,
   parameter int DATA_W_P = 8,
   parameter int ADDR_W_P = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W_P-1:0] wr_addr,
   input  logic [DATA_W_P-1:0] wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W_P-1:0] rd_addr,
   output logic [DATA_W_P-1:0] rd_data
);

   logic [DATA_W_P-1:0] mem_ff [DEPTH_P];
   logic [DATA_W_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so it can sit in a stalled beat.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/byte_ring_buffer_overwrite.sv
// Byte ring buffer with optional overwrite of the oldest data.
//
// Channels: req_ch carries one request per beat (write a byte, read a byte, or
// clear the queue) plus a last_in marker. rsp_ch returns exactly one beat per
// request with the byte read (zero unless a read succeeded), an accepted bit,
// the empty, full and overflow flags as they stand after the request, and
// last_out, a copy of last_in. csr_write_en/csr_write_data set the overwrite
// enable bit; write it only while no request is outstanding.
//
// Each response beat is registered and shows from the cycle after its request
// is accepted. Throughput is one request per cycle while the receiver takes
// every beat, set by the response register, which takes a new beat in the same
// cycle its old one leaves. The byte memory has separate write and read ports,
// and each request uses at most one of them.
//
// Reset empties the buffer, clears full and overflow, and disables overwrite.
// The byte memory itself is not cleared; only written bytes can ever be read.
// When the receiver stalls, the response beat holds and req_ch.ready drops
// until the response is taken; the pointer and flag state stays put meanwhile.
module byte_ring_buffer_overwrite import brbo_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   brbo_req_if.sink    req_ch,
   brbo_rsp_if.source  rsp_ch
);

   // Ring state.
   ptr_type wr_ptr_ff, wr_ptr_in;
   ptr_type rd_ptr_ff, rd_ptr_in;
   logic    empty_ff, empty_in;
   logic    full_ff, full_in;
   logic    ovf_ff, ovf_in;
   logic    ovw_en_ff;

   // Response stage.
   logic    rsp_valid_ff;
   logic    rsp_acc_ff, rsp_acc_in;
   logic    rsp_rd_ff, rsp_rd_in;
   logic    rsp_last_ff;

   logic     req_beat;
   logic     mem_we;
   byte_type mem_rd_data;

   // A new request may enter whenever the response register is free or is being
   // emptied in this same cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_beat     = req_ch.valid && req_ch.ready;

   // Next-state logic for one request. A write into a full buffer in overwrite mode
   // sets overflow and drags the read pointer along with the write pointer.
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      empty_in   = empty_ff;
      full_in    = full_ff;
      ovf_in     = ovf_ff;
      mem_we     = 1'b0;
      rsp_acc_in = 1'b0;
      rsp_rd_in  = 1'b0;
      case (req_ch.req_type)
         REQ_WRITE: begin
            if (ovw_en_ff || !full_ff) begin
               if (ovw_en_ff && full_ff && (wr_ptr_ff == rd_ptr_ff)) begin
                  ovf_in = 1'b1;
               end
               mem_we    = 1'b1;
               wr_ptr_in = ptr_next(wr_ptr_ff);
               if (wr_ptr_in == rd_ptr_ff) begin
                  full_in = 1'b1;
               end
               empty_in = 1'b0;
               if (ovw_en_ff && ovf_in) begin
                  rd_ptr_in = wr_ptr_in;
               end
               rsp_acc_in = 1'b1;
            end
         end
         REQ_READ: begin
            if (!empty_ff) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
               if (rd_ptr_in == wr_ptr_ff) begin
                  empty_in = 1'b1;
               end
               if (full_ff) begin
                  full_in = 1'b0;
                  ovf_in  = 1'b0;
               end
               rsp_acc_in = 1'b1;
               rsp_rd_in  = 1'b1;
            end
         end
         REQ_CLEAR: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            empty_in  = 1'b1;
            full_in   = 1'b0;
            ovf_in    = 1'b0;
         end
         default: begin
            // The unused request code leaves everything as it is.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         empty_ff  <= 1'b1;
         full_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
      end else if (req_beat) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         empty_ff  <= empty_in;
         full_ff   <= full_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovw_en_ff <= 1'b0;
      end else if (csr_write_en) begin
         ovw_en_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_acc_ff  <= rsp_acc_in;
         rsp_rd_ff   <= rsp_rd_in;
         rsp_last_ff <= req_ch.last_in;
      end
   end

   // The byte memory is read at the old read pointer in the same edge that
   // accepts the read, so the registered read data lines up with the response.
   brbo_ram #(
      .DEPTH_P  (DEPTH),
      .DATA_W_P ($bits(byte_type))
   ) u_ram (
      .clock   (clock),
      .wr_en   (req_beat && mem_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_ch.write_byte),
      .rd_en   (req_beat && rsp_rd_in),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rd_data)
   );

   // The ring state changes only when a request is taken, and that happens only
   // while no response is pending or as it leaves, so the live flags are the flags
   // that belong to the response on display.
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_byte  = rsp_rd_ff ? mem_rd_data : '0;
   assign rsp_ch.accepted   = rsp_acc_ff;
   assign rsp_ch.is_empty   = empty_ff;
   assign rsp_ch.is_full    = full_ff;
   assign rsp_ch.overflowed = ovf_ff;
   assign rsp_ch.last_out   = rsp_last_ff;

endmodule

// File: rtl/brbo_checker.sv
module brbo_checker import brbo_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type read_byte,
   input logic     accepted,
   input logic     is_empty,
   input logic     is_full,
   input logic     overflowed
);

   // Every accepted request shows its response beat on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no response after accepted request");

   // The buffer can never be empty and full at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(is_empty && is_full))
      else $error("empty and full reported together");

   // Overflow only exists while the buffer stays full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && overflowed) |-> is_full)
      else $error("overflow without full");

   // A rejected request never returns data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !accepted) |-> (read_byte == '0))
      else $error("data returned on a rejected request");

   // A stalled response keeps its flags.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(is_empty) && $stable(is_full) && $stable(overflowed)))
      else $error("stalled response changed");

endmodule

bind byte_ring_buffer_overwrite brbo_checker u_brbo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .read_byte  (rsp_ch.read_byte),
   .accepted   (rsp_ch.accepted),
   .is_empty   (rsp_ch.is_empty),
   .is_full    (rsp_ch.is_full),
   .overflowed (rsp_ch.overflowed)
);
